// ===== src/lkv_pkg.sv =====
// Package for the LRU key/value cache: request/response structs, field widths,
// register map constants. No dependencies.
package lkv_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned CAPFLD_W  = 4;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index 0 sits at byte address 0; index is paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic ACTION_PUT = 1'b0;
  localparam logic ACTION_GET = 1'b1;

  typedef struct packed {
    logic fire;
    logic is_get;
  } lkv_req_t;

  typedef struct packed {
    logic miss;
  } lkv_rsp_t;

endpackage

// ===== src/lkv_cfg.sv =====
// APB register block of the LRU key/value cache: capacity register with clamp.
// Depends on lkv_pkg.
module lkv_cfg
  import lkv_pkg::*;
#(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned CAP_W   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CAP_W-1:0]      capacity
);

  logic [CAP_W-1:0] capacity_next;
  logic [CAP_W-1:0] wr_val;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign wr_val = CAP_W'(pwdata[CAPFLD_W-1:0]);

  always_comb begin
    capacity_next = capacity;
    if (wr_en) begin
      if (wr_val == '0) begin
        capacity_next = CAP_W'(1);
      end else if (wr_val > CAP_W'(ENTRIES)) begin
        capacity_next = CAP_W'(ENTRIES);
      end else begin
        capacity_next = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(ENTRIES);
    end else begin
      capacity <= capacity_next;
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity) : '0;

endmodule

// ===== src/lkv_store.sv =====
// Entry store of the LRU key/value cache: parallel key match, age update,
// victim and free-slot selection, all in the same cycle as the request. Depends on lkv_pkg.
module lkv_store
  import lkv_pkg::*;
#(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CAP_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lkv_req_t              req,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  logic [CAP_W-1:0]      capacity,
  output lkv_rsp_t              rsp,
  output logic [FIELD_W-1:0]    rd_value
);

  localparam int unsigned AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [KEY_BITS-1:0]   entry_key   [ENTRIES];
  logic [VALUE_BITS-1:0] entry_value [ENTRIES];
  logic [AGE_W-1:0]      entry_age   [ENTRIES];
  logic [AGE_W-1:0]      entry_age_next [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid;
  logic [ENTRIES-1:0]    entry_valid_next;
  logic [CNT_W-1:0]      fill_count;
  logic [CNT_W-1:0]      fill_count_next;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    victim_oh;
  logic [ENTRIES-1:0]    free_oh;
  logic [ENTRIES-1:0]    sel_oh;
  logic [ENTRIES-1:0]    young_oh;
  logic [VALUE_BITS-1:0] hit_value;
  logic [CNT_W-1:0]      sel_age;
  logic [CNT_W-1:0]      oldest;
  logic                  hit;
  logic                  full;
  logic                  do_put;
  logic                  do_update;

  assign oldest = fill_count - CNT_W'(1);
  assign full   = (CMP_W'(fill_count) >= CMP_W'(capacity))
               || (fill_count >= CNT_W'(ENTRIES));

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = entry_valid[i] && (entry_key[i] == key);
      victim_oh[i] = entry_valid[i] && (CNT_W'(entry_age[i]) == oldest);
      if (match[i]) begin
        hit_value = hit_value | entry_value[i];
      end
    end
    free_oh = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_oh    = '0;
        free_oh[i] = 1'b1;
      end
    end
  end

  assign hit       = |match;
  assign do_put    = req.fire && (req.is_get == ACTION_PUT);
  assign do_update = req.fire && (hit || do_put);

  always_comb begin
    if (hit) begin
      sel_oh = match;
    end else if (full) begin
      sel_oh = victim_oh;
    end else begin
      sel_oh = free_oh;
    end
    // a fresh slot ages every valid entry
    sel_age = fill_count;
    if (hit || full) begin
      sel_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel_oh[i]) begin
          sel_age = sel_age | CNT_W'(entry_age[i]);
        end
      end
    end
  end

  always_comb begin
    entry_valid_next = entry_valid;
    fill_count_next  = fill_count;
    for (int i = 0; i < ENTRIES; i++) begin
      young_oh[i]       = entry_valid[i] && (CNT_W'(entry_age[i]) < sel_age);
      entry_age_next[i] = entry_age[i];
      if (do_update) begin
        if (sel_oh[i]) begin
          entry_age_next[i] = '0;
        end else if (young_oh[i]) begin
          entry_age_next[i] = entry_age[i] + AGE_W'(1);
        end
      end
    end
    if (do_put) begin
      entry_valid_next = entry_valid | sel_oh;
      if (!hit && !full) begin
        fill_count_next = fill_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fill_count  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else begin
      entry_valid <= entry_valid_next;
      fill_count  <= fill_count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= entry_age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_put && sel_oh[i]) begin
        entry_key[i]   <= key;
        entry_value[i] <= wr_value;
      end
    end
  end

  assign rsp.miss = (req.is_get == ACTION_GET) && !hit;
  assign rd_value = ((req.is_get == ACTION_GET) && hit) ? FIELD_W'(hit_value) : '0;

`ifndef NO_ASSERTIONS
  logic [ENTRIES-1:0] newest_oh;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      newest_oh[i] = entry_valid[i] && (entry_age[i] == '0);
    end
  end

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == fill_count)
    else $error("fill count differs from number of valid entries");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key matched more than one entry");

  a_one_newest: assert property (@(posedge clk) disable iff (rst)
    (fill_count != '0) |-> $onehot(newest_oh))
    else $error("most recent entry not unique");

  a_put_stores: assert property (@(posedge clk) disable iff (rst)
    do_put |=> (fill_count != '0))
    else $error("put left the store empty");
`endif

endmodule

// ===== src/lru_key_value_cache.sv =====
// Data path: input register, then result register; a stalled result beat holds the input register.
// Throughput: one beat per cycle while the result side is not stalled; the key match and age update
// for an item are computed between the input register and the result register.
// Reset: synchronous; clears valid marks, ages and fill count, capacity returns to ENTRIES.
// Keys and values are not reset; they are read only after being written.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // key[31:0], write_value[63:32]
  input  logic                  s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // read_value[31:0]
  output logic                  m_axis_tuser,  // status
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W = (CNT_W > CAPFLD_W) ? CNT_W : CAPFLD_W;

  logic                  in_valid;
  logic                  in_action;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  logic                  fire;
  logic [CAP_W-1:0]      capacity;
  lkv_req_t              req;
  lkv_rsp_t              rsp;
  logic [FIELD_W-1:0]    rd_value;

  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action <= s_axis_tuser;
      in_key    <= KEY_BITS'(s_axis_tdata[FIELD_W-1:0]);
      in_value  <= VALUE_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    end
  end

  assign req.fire   = fire;
  assign req.is_get = in_action;

  lkv_cfg #(
    .ENTRIES (ENTRIES),
    .CAP_W   (CAP_W)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lkv_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CAP_W      (CAP_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .key      (in_key),
    .wr_value (in_value),
    .capacity (capacity),
    .rsp      (rsp),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= rd_value;
      m_axis_tuser <= rsp.miss;
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for lru_key_value_cache: stream put/get requests with random gaps and stalls,
// predict replies with an LRU store model of its own or a directed table, reprogram capacity over APB.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
module testbench
  import lkv_pkg::*;
();

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned POOL_DEPTH = 16;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_MISS = 1'b1;

  localparam logic FROM_TABLE = 1'b1;
  localparam logic FROM_MODEL = 1'b0;

  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic        miss;
    logic [31:0] data;
  } reply_t;

  typedef struct packed {
    logic        act;
    logic [31:0] key;
    logic [31:0] wval;
    logic        typed;
    logic        miss;
    logic [31:0] data;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ACTION_GET, 32'h0000_0000, 32'h0000_0000, FROM_TABLE, ST_MISS, 32'h0000_0000},
    '{ACTION_PUT, 32'h0000_0000, 32'hFFFF_FFFF, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0000, 32'h0000_0000, FROM_TABLE, ST_OK,   32'hFFFF_FFFF},
    '{ACTION_PUT, 32'hFFFF_FFFF, 32'h0000_0000, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_PUT, 32'h0000_0000, 32'h1234_5678, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0000, 32'h0000_0000, FROM_TABLE, ST_OK,   32'h1234_5678},
    '{ACTION_PUT, 32'h0000_0001, 32'h1111_1111, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_PUT, 32'h0000_0002, 32'h2222_2222, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'hFFFF_FFFF, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0000, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000},
    '{ACTION_PUT, 32'h0000_0003, 32'h3333_3333, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0001, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0002, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0003, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000},
    '{ACTION_PUT, 32'h0000_0002, 32'hAAAA_AAAA, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0002, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'hA5A5_A5A5, 32'hDEAD_BEEF, FROM_TABLE, ST_MISS, 32'h0000_0000},
    '{ACTION_PUT, 32'h8000_0000, 32'h55AA_55AA, FROM_TABLE, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h8000_0000, 32'h0000_0000, FROM_TABLE, ST_OK,   32'h55AA_55AA},
    '{ACTION_GET, 32'h7FFF_FFFF, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000},
    '{ACTION_GET, 32'h0000_0000, 32'h0000_0000, FROM_MODEL, ST_OK,   32'h0000_0000}
  };

  localparam logic [31:0] PHASE_CAP [PHASES] = '{
    32'd0, 32'd2, 32'd5, 32'd15, 32'd8, 32'd1, 32'd0, 32'd4
  };
  localparam int unsigned PHASE_BEATS [PHASES] = '{100, 100, 100, 150, 100, 100, 100, 100};

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata;   // key[31:0], write_value[63:32]
  logic                  s_axis_tuser;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;   // read_value[31:0]
  logic                  m_axis_tuser;   // status
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lru_key_value_cache uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  logic [31:0] slot_key  [SLOTS];
  logic [31:0] slot_val  [SLOTS];
  bit          slot_live [SLOTS];
  int unsigned slot_age  [SLOTS];
  int unsigned live_count;
  int unsigned cap_now;

  reply_t      pending_replies [$];
  logic [31:0] key_pool [POOL_DEPTH];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_gap_max;
  int unsigned recv_stall_max;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_armed;

  initial clk = 1'b0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("lru_key_value_cache test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
  endtask

  function automatic void promote(int s);
    int unsigned old_age;
    old_age = slot_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic reply_t serve_request(logic act, logic [31:0] k, logic [31:0] v);
    reply_t r;
    int     hit;
    int     s;
    r   = '0;
    hit = -1;
    s   = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && slot_live[i] && slot_key[i] == k) hit = i;
    if (act == ACTION_GET) begin
      if (hit < 0) begin
        r.miss = ST_MISS;
      end else begin
        promote(hit);
        r.data = slot_val[hit];
      end
    end else if (hit >= 0) begin
      slot_val[hit] = v;
      promote(hit);
    end else if (live_count >= cap_now) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i] && (s < 0 || slot_age[i] > slot_age[s])) s = i;
      slot_key[s] = k;
      slot_val[s] = v;
      promote(s);
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && !slot_live[i]) s = i;
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i]) slot_age[i]++;
      slot_key[s]  = k;
      slot_val[s]  = v;
      slot_live[s] = 1'b1;
      slot_age[s]  = 0;
      live_count++;
    end
    return r;
  endfunction

  function automatic int unsigned clamp_capacity(logic [31:0] wdata);
    int unsigned c;
    c = 32'(wdata[CAPFLD_W-1:0]);
    if (c < 1) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  task automatic send_request(input logic act, input logic [31:0] k, input logic [31:0] v,
                              input logic typed, input reply_t typed_reply);
    int unsigned gap;
    reply_t      r;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    r = serve_request(act, k, v);
    pending_replies.push_back(typed ? typed_reply : r);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] wdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_now = clamp_capacity(wdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_traffic(input int unsigned beats, input int unsigned pool_size,
                             input bit pause_midway);
    logic        act;
    logic [31:0] k;
    for (int unsigned n = 0; n < beats; n++) begin
      act = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_size - 1)];
      else k = $urandom;
      send_request(act, k, $urandom, FROM_MODEL, '0);
      if (pause_midway && n == beats / 2) drain_replies();
    end
  endtask

  // receiver: per-beat stall plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !rst;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_axis_tdata, '0);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.miss)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.miss));
        if (m_axis_tdata !== want.data) report_mismatch("read_value", m_axis_tdata, want.data);
      end
      stall_left = $urandom_range(0, recv_stall_max);
    end
  end

  initial begin
    reply_t      typed_reply;
    int unsigned pool_size;
    logic [31:0] cap_word;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ACTION_PUT;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatches     = 0;
    cycles         = 0;
    stall_left     = 0;
    hold_left      = 0;
    hold_armed     = 1'b0;
    send_gap_max   = 7;
    recv_stall_max = 7;
    live_count     = 0;
    cap_now        = SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_live[i] = 1'b0;
      slot_age[i]  = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_capacity(32'd3);
    foreach (DIRECTED[i]) begin
      typed_reply.miss = DIRECTED[i].miss;
      typed_reply.data = DIRECTED[i].data;
      send_request(DIRECTED[i].act, DIRECTED[i].key, DIRECTED[i].wval,
                   DIRECTED[i].typed, typed_reply);
    end
    drain_replies();

    for (int p = 0; p < PHASES; p++) begin
      cap_word = (p == 6) ? $urandom : PHASE_CAP[p];
      write_capacity(cap_word);
      pool_size = cap_now + 3;
      for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
      send_gap_max   = (p % 3 == 0) ? 0 : 7;
      recv_stall_max = (p % 4 == 1) ? 0 : 7;
      if (p == 3) hold_armed = 1'b1;
      run_traffic(PHASE_BEATS[p], pool_size, p == 2);
      drain_replies();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
